// File: rtl/core/lgr_pkg.sv
// ----------------------------------------------------------------------------
// lgr_pkg
// Shared constants and types for the life generation row stream unit.
// ----------------------------------------------------------------------------
package lgr_pkg;

    // row geometry
    localparam int ROW_W     = 64;
    localparam int MAX_WIDTH = 64;
    localparam int WIDTH_W   = 7;
    localparam int HEIGHT_W  = 16;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  GRID_WIDTH_RESET  = 7'd64;
    localparam logic [HEIGHT_W-1:0] GRID_HEIGHT_RESET = 16'd64;

    // neighbor counts of the life rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // output word: next_row_cells then row_number
    localparam int M_TDATA_W = ROW_W + HEIGHT_W;

    // one result word
    typedef struct packed {
        logic [ROW_W-1:0]    cells;
        logic [HEIGHT_W-1:0] row_num;
        logic                last;
    } result_t;

    // write strobes into the result queue
    typedef struct packed {
        logic slot0;
        logic slot1;
    } push_t;

endpackage

// File: rtl/core/lgr_cell_lane.sv
// ----------------------------------------------------------------------------
// lgr_cell_lane
// One cell of the life rule: counts the eight neighbors and decides the cell.
// ----------------------------------------------------------------------------
module lgr_cell_lane (
    input  logic [2:0] up,     // left, center, right of the row above
    input  logic [2:0] mid,    // left, center, right of the own row
    input  logic [2:0] down,   // left, center, right of the row below
    input  logic       enable, // column in use
    output logic       next
);

    logic [3:0] count;

    // neighbor count, center excluded
    assign count = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
                 + 4'(mid[0]) + 4'(mid[2])
                 + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

    // birth on three, survival on two or three
    assign next = enable & ((count == lgr_pkg::BIRTH_COUNT)
                         | (mid[1] & (count == lgr_pkg::SURVIVE_COUNT)));

endmodule

// File: rtl/core/lgr_stencil.sv
// ----------------------------------------------------------------------------
// lgr_stencil
// One lane per column over three rows, merged into the next-generation row.
// ----------------------------------------------------------------------------
module lgr_stencil (
    input  logic [lgr_pkg::ROW_W-1:0] up,
    input  logic [lgr_pkg::ROW_W-1:0] mid,
    input  logic [lgr_pkg::ROW_W-1:0] down,
    input  logic [lgr_pkg::ROW_W-1:0] mask,
    output logic [lgr_pkg::ROW_W-1:0] next_row
);

    logic [lgr_pkg::ROW_W+1:0] up_pad;
    logic [lgr_pkg::ROW_W+1:0] mid_pad;
    logic [lgr_pkg::ROW_W+1:0] down_pad;
    logic [lgr_pkg::ROW_W-1:0] lane_out;

    // dead border on both sides, unused columns dead
    assign up_pad   = {1'b0, up & mask, 1'b0};
    assign mid_pad  = {1'b0, mid & mask, 1'b0};
    assign down_pad = {1'b0, down & mask, 1'b0};

    // cell lanes
    for (genvar j = 0; j < lgr_pkg::ROW_W; j++) begin : g_lane
        lgr_cell_lane u_lane (
            .up     (up_pad[j+2:j]),
            .mid    (mid_pad[j+2:j]),
            .down   (down_pad[j+2:j]),
            .enable (mask[j]),
            .next   (lane_out[j])
        );
    end

    // merge lanes into the row word
    assign next_row = lane_out & mask;

endmodule

// File: rtl/core/lgr_result_fifo.sv
// ----------------------------------------------------------------------------
// lgr_result_fifo
// Small result queue, up to two words written and one word read per cycle.
// ----------------------------------------------------------------------------
module lgr_result_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  lgr_pkg::push_t   push,
    input  lgr_pkg::result_t wr_data0,
    input  lgr_pkg::result_t wr_data1,
    input  logic             rd_ready,
    output logic             rd_valid,
    output lgr_pkg::result_t rd_data,
    output logic             has_room
);

    lgr_pkg::result_t mem [lgr_pkg::FIFO_DEPTH];

    logic [lgr_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lgr_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lgr_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                           pop;

    // status
    assign rd_valid = (count_reg != '0);
    assign has_room = (count_reg <= lgr_pkg::FIFO_CNT_W'(lgr_pkg::FIFO_DEPTH - 2));
    assign pop      = rd_valid & rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    // pointer and fill arithmetic
    always_comb begin
        wr_ptr_next = wr_ptr_reg + lgr_pkg::FIFO_PTR_W'(push.slot0)
                                 + lgr_pkg::FIFO_PTR_W'(push.slot1);
        rd_ptr_next = rd_ptr_reg + lgr_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + lgr_pkg::FIFO_CNT_W'(push.slot0)
                                + lgr_pkg::FIFO_CNT_W'(push.slot1)
                                - lgr_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.slot0) begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (push.slot1) begin
            mem[wr_ptr_reg + lgr_pkg::FIFO_PTR_W'(1)] <= wr_data1;
        end
    end

    // fill level stays within the queue
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= lgr_pkg::FIFO_CNT_W'(lgr_pkg::FIFO_DEPTH))
        else $error("result queue fill level out of range");

    // second slot is written only together with the first
    a_slot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        push.slot1 |-> push.slot0)
        else $error("second result slot written alone");

    // never written while short of room for two words
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.slot0 |-> (count_reg <= lgr_pkg::FIFO_CNT_W'(lgr_pkg::FIFO_DEPTH - 2)))
        else $error("result queue written without room");

endmodule

// File: rtl/core/life_generation_row_stream_unit.sv
// ----------------------------------------------------------------------------
// life_generation_row_stream_unit
// One Conway Life generation on a bounded grid, one row word in per cycle.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         row_cells (tdata[63:0])
//  m_axis    out        next_row_cells (tdata[63:0]), row_number (tdata[79:64]),
//                       frame_last (tlast)
//  cfg       in         cfg_index selects grid_width (0) or grid_height (1)
//
//  One row word is accepted per cycle while s_tready is high; two stencils of
//  64 cell lanes each evaluate in the accept cycle, results queued at its end.
//  The final row of a frame yields two result words (one in a one-row frame);
//  the four-entry output queue absorbs them.
//  Reset (aresetn low, synchronous) clears the row history and row counter and
//  sets grid_width 64, grid_height 64. Output stalls fill the queue and then
//  drop s_tready while fewer than two entries are free.
// ----------------------------------------------------------------------------
module life_generation_row_stream_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input rows
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lgr_pkg::ROW_W-1:0]       s_tdata,   // [63:0] row_cells
    // result rows
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lgr_pkg::M_TDATA_W-1:0]   m_tdata,   // [63:0] next_row_cells,
                                                       // [79:64] row_number
    output logic                            m_tlast,   // frame_last
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [lgr_pkg::WIDTH_W-1:0]  grid_width_reg;
    logic [lgr_pkg::HEIGHT_W-1:0] grid_height_reg;
    logic [lgr_pkg::ROW_W-1:0]    row_above_reg, row_above_next;
    logic [lgr_pkg::ROW_W-1:0]    row_current_reg, row_current_next;
    logic [lgr_pkg::HEIGHT_W-1:0] rows_seen_reg, rows_seen_next;

    logic [lgr_pkg::ROW_W-1:0]    mask;
    logic [lgr_pkg::ROW_W-1:0]    row_in;
    logic [lgr_pkg::ROW_W-1:0]    above_b;
    logic [lgr_pkg::ROW_W-1:0]    cells_a;
    logic [lgr_pkg::ROW_W-1:0]    cells_b;
    logic [lgr_pkg::HEIGHT_W-1:0] last_idx;
    logic                         s_fire;
    logic                         has_prev;
    logic                         frame_end;
    logic                         fifo_room;
    lgr_pkg::result_t             res_a, res_b, slot0_data, rd_data;
    lgr_pkg::push_t               push;

    // column mask from the configured width
    for (genvar j = 0; j < lgr_pkg::ROW_W; j++) begin : g_mask
        if (j < lgr_pkg::MAX_WIDTH) begin : g_on
            assign mask[j] = (grid_width_reg > lgr_pkg::WIDTH_W'(j));
        end else begin : g_off
            assign mask[j] = 1'b0;
        end
    end

    // frame position
    assign s_fire    = s_tvalid & s_tready;
    assign row_in    = s_tdata & mask;
    assign last_idx  = grid_height_reg - lgr_pkg::HEIGHT_W'(1);
    assign has_prev  = (rows_seen_reg != '0);
    assign frame_end = (rows_seen_reg >= last_idx);
    assign above_b   = has_prev ? row_current_reg : '0;

    // previous row, from the two stored rows and the incoming one
    lgr_stencil u_stencil_a (
        .up       (row_above_reg),
        .mid      (row_current_reg),
        .down     (row_in),
        .mask     (mask),
        .next_row (cells_a)
    );

    // final row of the frame, dead row below
    lgr_stencil u_stencil_b (
        .up       (above_b),
        .mid      (row_in),
        .down     ('0),
        .mask     (mask),
        .next_row (cells_b)
    );

    // result words and queue strobes
    always_comb begin
        res_a.cells   = cells_a;
        res_a.row_num = rows_seen_reg - lgr_pkg::HEIGHT_W'(1);
        res_a.last    = 1'b0;
        res_b.cells   = cells_b;
        res_b.row_num = rows_seen_reg;
        res_b.last    = 1'b1;
        slot0_data    = has_prev ? res_a : res_b;
        push.slot0    = s_fire & (has_prev | frame_end);
        push.slot1    = s_fire & has_prev & frame_end;
    end

    // row history update
    always_comb begin
        row_above_next   = row_above_reg;
        row_current_next = row_current_reg;
        rows_seen_next   = rows_seen_reg;
        if (s_fire) begin
            if (frame_end) begin
                row_above_next   = '0;
                row_current_next = '0;
                rows_seen_next   = '0;
            end else begin
                row_above_next   = above_b;
                row_current_next = row_in;
                rows_seen_next   = rows_seen_reg + lgr_pkg::HEIGHT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_above_reg   <= '0;
            row_current_reg <= '0;
            rows_seen_reg   <= '0;
        end else begin
            row_above_reg   <= row_above_next;
            row_current_reg <= row_current_next;
            rows_seen_reg   <= rows_seen_next;
        end
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= lgr_pkg::GRID_WIDTH_RESET;
            grid_height_reg <= lgr_pkg::GRID_HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lgr_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[lgr_pkg::WIDTH_W-1:0];
                lgr_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output queue
    lgr_result_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_data0 (slot0_data),
        .wr_data1 (res_b),
        .rd_ready (m_tready),
        .rd_valid (m_tvalid),
        .rd_data  (rd_data),
        .has_room (fifo_room)
    );

    assign s_tready = fifo_room;
    assign m_tdata  = {rd_data.row_num, rd_data.cells};
    assign m_tlast  = rd_data.last;

    // frame end clears the history and the row counter
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && frame_end |=> rows_seen_reg == '0 && row_above_reg == '0
                                && row_current_reg == '0)
        else $error("row history not cleared at frame end");

    // inside a frame the counter steps by one per word
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !frame_end |=> rows_seen_reg == $past(rows_seen_reg) + 16'd1)
        else $error("row counter did not advance");

    // counter idle without input words
    a_row_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(rows_seen_reg))
        else $error("row counter moved without input");

endmodule
